[rtl/crmm_pkg.sv]
// ----------------------------------------------------------------------------
// crmm_pkg
// shared types and constants for the receive mailbox matcher
// ----------------------------------------------------------------------------
package crmm_pkg;

   localparam int SlotsDefault = 64;

   localparam logic [11:0] SdoReplyBase  = 12'h580;
   localparam logic [7:0]  SdoWriteReply = 8'h60;
   localparam logic [7:0]  SdoReadReply  = 8'h42;
   localparam logic [3:0]  PdoLength     = 4'd4;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_SDO   = 2'd1,
      OP_PDO   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [10:0] frame_id;
      logic [3:0]  frame_length;
      logic [63:0] frame_data;
      logic [10:0] request_address;
      logic        is_write;
      logic [15:0] object_index;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] received_value;
      logic        slot_replaced;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      opcode_type  op;
      logic        id_ok;
      logic [10:0] want_id;
      logic [7:0]  want_cmd;
      logic [15:0] want_obj;
      logic [3:0]  frame_length;
      logic [63:0] frame_data;
   } cmd_type;

endpackage

[rtl/can_receive_mailbox_matcher_unit.sv]
// ----------------------------------------------------------------------------
// can_receive_mailbox_matcher_unit
// receive mailbox for standard frames with reply lookup by slot scan
// ----------------------------------------------------------------------------
//  channel   handshake           word
//  request   start / busy        req  (req_type)
//  response  rsp_strobe          rsp  (rsp_type)
//
//  a store walks the full bits in the scan engine until it finds a free slot,
//  else it replaces the slot at the replace pointer; a lookup does one slot
//  memory read a cycle; an unused opcode goes straight to the response.
//  a two-entry command queue lets a new word in while the engine works.
//  reset clears all full bits and the replace pointer at once.
//  the response strobe lasts one cycle; the receiver cannot stall it.
module can_receive_mailbox_matcher_unit
   import crmm_pkg::*;
#(
   parameter int SLOTS = SlotsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   logic    cmd_valid, cmd_taken;
   cmd_type cmd;

   crmm_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req_word),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_taken(cmd_taken)
   );

   crmm_back #(.SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_taken(cmd_taken), .rsp_strobe(rsp_strobe), .rsp(rsp_word)
   );

endmodule

[rtl/crmm_front.sv]
// ----------------------------------------------------------------------------
// crmm_front
// accepts a request word, classifies it and queues the command
// ----------------------------------------------------------------------------
module crmm_front
   import crmm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_taken
);

   cmd_type     q_ff [2];
   logic [1:0]  cnt_ff;
   logic        rd_ff, wr_ff;
   logic        push, pop;
   cmd_type     c_in;
   logic [11:0] sdo_id;

   assign busy      = (cnt_ff == 2'd2);
   assign push      = start && !busy;
   assign pop       = cmd_taken && (cnt_ff != 2'd0);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign sdo_id    = SdoReplyBase + {1'b0, req.request_address};

   always_comb begin
      c_in.op           = opcode_type'(req.opcode);
      c_in.frame_length = req.frame_length;
      c_in.frame_data   = req.frame_data;
      c_in.want_obj     = req.object_index;
      c_in.want_cmd     = req.is_write ? SdoWriteReply : SdoReadReply;
      if (req.opcode == OP_SDO) begin
         c_in.want_id = sdo_id[10:0];
         c_in.id_ok   = !sdo_id[11];
      end else begin
         c_in.want_id = (req.opcode == OP_STORE) ? req.frame_id : req.request_address;
         c_in.id_ok   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= c_in;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

[rtl/crmm_back.sv]
// ----------------------------------------------------------------------------
// crmm_back
// scans the slot store one entry a cycle and carries out a command
// ----------------------------------------------------------------------------
module crmm_back
   import crmm_pkg::*;
#(
   parameter int SLOTS = SlotsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_taken,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [AW:0] Last = (AW+1)'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE, ST_SCAN, ST_CHECK, ST_DONE
   } state_type;

   logic [63:0] pay_mem [SLOTS];
   logic [10:0] id_mem  [SLOTS];
   logic [3:0]  len_mem [SLOTS];
   logic [SLOTS-1:0] full_ff;

   state_type   state_ff;
   cmd_type     c_ff;
   logic [AW:0] idx_ff;
   logic [AW-1:0] chk_ff;
   logic [AW-1:0] rp_ff;
   logic [63:0] rpay_ff;
   logic [10:0] rid_ff;
   logic [3:0]  rlen_ff;
   logic        rfull_ff;
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic        match;

   assign cmd_taken  = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      match = 1'b0;
      if (rfull_ff && c_ff.id_ok && rid_ff == c_ff.want_id) begin
         if (c_ff.op == OP_SDO)
            match = rpay_ff[7:0] == c_ff.want_cmd && rpay_ff[23:8] == c_ff.want_obj;
         else
            match = rlen_ff == PdoLength;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pay_mem[wr_addr] <= c_ff.frame_data;
         id_mem[wr_addr]  <= c_ff.want_id;
         len_mem[wr_addr] <= c_ff.frame_length;
      end
      rpay_ff <= pay_mem[idx_ff[AW-1:0]];
      rid_ff  <= id_mem[idx_ff[AW-1:0]];
      rlen_ff <= len_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         full_ff       <= '0;
         rp_ff         <= '0;
         idx_ff        <= '0;
         chk_ff        <= '0;
         rfull_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
         wr_en         <= 1'b0;
         wr_addr       <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         wr_en         <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (cmd_valid) begin
                  c_ff     <= cmd;
                  rsp_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // store: look at full bits; lookups: prime the memory read; unused opcode: finish
               if (c_ff.op == OP_STORE) begin
                  if (!full_ff[idx_ff[AW-1:0]]) begin
                     wr_en   <= 1'b1;
                     wr_addr <= idx_ff[AW-1:0];
                     full_ff[idx_ff[AW-1:0]] <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (idx_ff == Last) begin
                     wr_en   <= 1'b1;
                     wr_addr <= rp_ff;
                     rp_ff   <= (rp_ff == Last[AW-1:0]) ? '0 : rp_ff + 1'b1;
                     rsp_ff.slot_replaced <= 1'b1;
                     state_ff <= ST_DONE;
                  end else idx_ff <= idx_ff + 1'b1;
               end else if (c_ff.op == OP_NONE) begin
                  state_ff <= ST_DONE;
               end else begin
                  rfull_ff <= full_ff[idx_ff[AW-1:0]];
                  chk_ff   <= idx_ff[AW-1:0];
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (match) begin
                  rsp_ff.hit            <= 1'b1;
                  rsp_ff.received_value <= (c_ff.op == OP_SDO) ? rpay_ff[63:32]
                                                               : rpay_ff[31:0];
                  full_ff[chk_ff] <= 1'b0;
                  state_ff <= ST_DONE;
               end else if (chk_ff == Last[AW-1:0]) begin
                  state_ff <= ST_DONE;
               end else begin
                  rfull_ff <= full_ff[idx_ff[AW-1:0]];
                  chk_ff   <= idx_ff[AW-1:0];
                  idx_ff   <= idx_ff + 1'b1;
               end
            end
            ST_DONE: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
